FILE: sv/offc_pkg.sv
// Shared types and constants of the optical flow frame compensator.
// Used by offc_ctrl, offc_dp and optical_flow_frame_compensator_top; no dependencies.
package offc_pkg;

    // Input action codes.
    localparam logic ACT_BYTE   = 1'b0;
    localparam logic ACT_UPDATE = 1'b1;

    // Configuration register indexes.
    localparam logic REG_SCALE = 1'b0;
    localparam logic REG_RATE  = 1'b1;

    localparam logic [15:0] SCALE_RESET = 16'd8214;
    localparam logic [15:0] RATE_RESET  = 16'd669;

    // Frame format.
    localparam int WIN_LEN = 9;
    localparam logic [7:0] HDR_BYTE = 8'hFE;
    localparam logic [7:0] LEN_BYTE = 8'h04;
    localparam logic [7:0] FTR_BYTE = 8'hAA;

    // Byte counter.
    localparam logic [6:0] CNT_MAX     = 7'd127;
    localparam logic [6:0] CNT_FRAME   = 7'd9;
    localparam logic [6:0] FLUSH_LIMIT = 7'd100;

    // Compensation arithmetic: comp = floor(floor((8*A - 125*R) / 2^14) / 125).
    // The dividend is biased by 125 * 2^31 so the divider only sees positive values.
    // The 39-bit dividend is divided as a 19-bit upper digit and a 27-bit lower
    // digit (upper remainder and the low 20 bits), each by reciprocal
    // multiplication: floor(x / 125) = (x * DIV_RECIP) >> DIV_RSH for x < 2^27.
    localparam int          DIV_W     = 39;
    localparam logic [6:0]  DIV_CONST = 7'd125;
    localparam logic [DIV_W-1:0] DIV_BIAS = 39'd268435456000;
    localparam int          DIV_SPLIT = 20;
    localparam int          DIV_RSH   = 34;
    localparam logic [27:0] DIV_RECIP = 28'd137438954;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_acc;    // an input item is transferred this cycle
        logic mul1;      // first products
        logic mul2;      // second products
        logic sub;       // combine altitude and rate terms
        logic ofs;       // shift, bias and load the dividers
        logic div_hi;    // quotient of the upper digit
        logic div_rem;   // remainder of the upper digit
        logic div_lo;    // quotient of the lower digit
        logic finish;    // remove bias, saturate, store compensated motion
        logic out_load;  // load the result register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic frame_latched;
        logic out_free;
    } t_dp_sts;

endpackage

FILE: sv/offc_ctrl.sv
// Controller state machine of the optical flow frame compensator.
// Depends on offc_pkg for the command and status structs.
module offc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_action,
    input  offc_pkg::t_dp_sts i_sts,
    output logic              o_in_stall,
    output offc_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_SUB, S_OFS, S_DIVH, S_DIVR, S_DIVL, S_FIN, S_OUT
    } t_state;

    t_state      r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.in_acc = 1'b1;
                    if (i_action == offc_pkg::ACT_UPDATE) begin
                        n_state = i_sts.frame_latched ? S_MUL1 : S_OUT;
                    end
                end
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_SUB;
            end
            S_SUB: begin
                o_cmd.sub = 1'b1;
                n_state   = S_OFS;
            end
            S_OFS: begin
                o_cmd.ofs = 1'b1;
                n_state   = S_DIVH;
            end
            S_DIVH: begin
                o_cmd.div_hi = 1'b1;
                n_state      = S_DIVR;
            end
            S_DIVR: begin
                o_cmd.div_rem = 1'b1;
                n_state       = S_DIVL;
            end
            S_DIVL: begin
                o_cmd.div_lo = 1'b1;
                n_state      = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: sv/offc_dp.sv
// Datapath of the optical flow frame compensator: byte window, frame latch,
// multipliers, constant dividers and result register. Depends on offc_pkg.
module offc_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  offc_pkg::t_dp_cmd i_cmd,
    output offc_pkg::t_dp_sts o_sts,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_action,
    input  logic [7:0]        i_rx_byte,
    input  logic signed [15:0] i_roll_rate,
    input  logic signed [15:0] i_pitch_rate,
    input  logic [15:0]       i_altitude_mm,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic              o_frame_found,
    output logic signed [15:0] o_x_motion_raw,
    output logic signed [15:0] o_y_motion_raw,
    output logic [7:0]        o_frame_quality,
    output logic signed [31:0] o_x_compensated,
    output logic signed [31:0] o_y_compensated
);

    localparam int NL = 2;  // lane 0 is x (pitch), lane 1 is y (roll)

    // Configuration.
    logic [15:0] r_scale_coef, r_rate_coef;

    // Frame parsing state.
    logic [7:0]  r_win [offc_pkg::WIN_LEN];
    logic [6:0]  r_count;
    logic        r_latched;
    logic [15:0] r_lat_x, r_lat_y;
    logic [7:0]  r_lat_q;

    // Update operands and arithmetic pipeline.
    logic [15:0]                    r_alt;
    logic signed [15:0]             r_rate   [NL];
    logic signed [32:0]             r_p      [NL];
    logic signed [32:0]             r_r      [NL];
    logic signed [49:0]             r_a      [NL];
    logic signed [39:0]             r_r125   [NL];
    logic signed [52:0]             r_m      [NL];
    logic [offc_pkg::DIV_W-1:0]     r_dq     [NL];
    logic [12:0]                    r_qh     [NL];
    logic [6:0]                     r_rh     [NL];
    logic [19:0]                    r_ql     [NL];
    logic signed [31:0]             r_comp   [NL];

    logic [6:0]  cnt_inc;
    logic        match;
    logic [15:0] motion [NL];

    logic [26:0]                div_arg [NL];
    logic [54:0]                div_prod[NL];
    logic [18:0]                qh125   [NL];
    logic [18:0]                rh_full [NL];
    logic signed [38:0]         t_sh   [NL];
    logic signed [40:0]         q_full [NL];
    logic signed [31:0]         q_sat  [NL];

    logic r_out_valid;

    // Byte handling: the window after this shift is checked for a frame.
    assign cnt_inc = (r_count == offc_pkg::CNT_MAX) ? r_count : r_count + 7'd1;
    assign match   = (cnt_inc >= offc_pkg::CNT_FRAME) && (r_win[1] == offc_pkg::HDR_BYTE)
                     && (r_win[2] == offc_pkg::LEN_BYTE) && (i_rx_byte == offc_pkg::FTR_BYTE);

    assign motion[0] = r_lat_x;
    assign motion[1] = r_lat_y;

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            // One 27 by 28 bit reciprocal product per lane, shared by both digits.
            div_arg[l]  = i_cmd.div_lo
                          ? {r_rh[l], r_dq[l][offc_pkg::DIV_SPLIT-1:0]}
                          : {8'd0, r_dq[l][offc_pkg::DIV_W-1:offc_pkg::DIV_SPLIT]};
            div_prod[l] = {28'd0, div_arg[l]} * {27'd0, offc_pkg::DIV_RECIP};
            qh125[l]    = {6'd0, r_qh[l]} * {12'd0, offc_pkg::DIV_CONST};
            rh_full[l]  = r_dq[l][offc_pkg::DIV_W-1:offc_pkg::DIV_SPLIT] - qh125[l];
            t_sh[l]     = 39'(r_m[l] >>> 14);
            q_full[l]   = $signed({8'b0, r_qh[l], r_ql[l]}) - $signed(41'sd2147483648);
            if (q_full[l] > $signed(41'sd2147483647)) begin
                q_sat[l] = 32'sh7FFFFFFF;
            end else if (q_full[l] < -$signed(41'sd2147483648)) begin
                q_sat[l] = 32'sh80000000;
            end else begin
                q_sat[l] = 32'(q_full[l]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_coef <= offc_pkg::SCALE_RESET;
            r_rate_coef  <= offc_pkg::RATE_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == offc_pkg::REG_SCALE) begin
                r_scale_coef <= i_cfg_data;
            end else begin
                r_rate_coef <= i_cfg_data;
            end
        end
    end

    // Window, counter, frame latch and last compensated values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < offc_pkg::WIN_LEN; k++) begin
                r_win[k] <= '0;
            end
            r_count   <= '0;
            r_latched <= 1'b0;
            r_lat_x   <= '0;
            r_lat_y   <= '0;
            r_lat_q   <= '0;
            r_comp[0] <= '0;
            r_comp[1] <= '0;
        end else begin
            if (i_cmd.in_acc && (i_action == offc_pkg::ACT_BYTE)) begin
                for (int k = 0; k < offc_pkg::WIN_LEN - 1; k++) begin
                    r_win[k] <= r_win[k+1];
                end
                r_win[offc_pkg::WIN_LEN-1] <= i_rx_byte;
                r_count <= cnt_inc;
                if (match) begin
                    r_lat_x   <= {r_win[4], r_win[3]};
                    r_lat_y   <= {r_win[6], r_win[5]};
                    r_lat_q   <= r_win[8];
                    r_latched <= 1'b1;
                end
            end
            if (i_cmd.finish) begin
                r_comp[0] <= q_sat[0];
                r_comp[1] <= q_sat[1];
            end
            if (i_cmd.out_load) begin
                if (r_latched) begin
                    r_count   <= '0;
                    r_latched <= 1'b0;
                end else if (r_count >= offc_pkg::FLUSH_LIMIT) begin
                    r_count <= '0;
                end
            end
        end
    end

    // Arithmetic pipeline and reciprocal dividers by the constant 125.
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_acc) begin
            r_alt     <= i_altitude_mm;
            r_rate[0] <= i_pitch_rate;
            r_rate[1] <= i_roll_rate;
        end
        for (int l = 0; l < NL; l++) begin
            if (i_cmd.mul1) begin
                r_p[l] <= 33'($signed(motion[l]) * $signed({1'b0, r_alt}));
                r_r[l] <= 33'(r_rate[l] * $signed({1'b0, r_rate_coef}));
            end
            if (i_cmd.mul2) begin
                r_a[l]    <= 50'(r_p[l] * $signed({1'b0, r_scale_coef}));
                r_r125[l] <= (40'(r_r[l]) <<< 7) - (40'(r_r[l]) <<< 2) + 40'(r_r[l]);
            end
            if (i_cmd.sub) begin
                r_m[l] <= (53'(r_a[l]) <<< 3) - 53'(r_r125[l]);
            end
            if (i_cmd.ofs) begin
                r_dq[l] <= offc_pkg::DIV_W'(t_sh[l]) + offc_pkg::DIV_BIAS;
            end
            if (i_cmd.div_hi) begin
                r_qh[l] <= div_prod[l][offc_pkg::DIV_RSH+12:offc_pkg::DIV_RSH];
            end
            if (i_cmd.div_rem) begin
                r_rh[l] <= rh_full[l][6:0];
            end
            if (i_cmd.div_lo) begin
                r_ql[l] <= div_prod[l][offc_pkg::DIV_RSH+19:offc_pkg::DIV_RSH];
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_frame_found     <= r_latched;
            o_x_motion_raw    <= r_lat_x;
            o_y_motion_raw    <= r_lat_y;
            o_frame_quality   <= r_lat_q;
            o_x_compensated   <= r_comp[0];
            o_y_compensated   <= r_comp[1];
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_sts.frame_latched = r_latched;
    assign o_sts.out_free      = !r_out_valid || !i_out_stall;

endmodule

FILE: sv/optical_flow_frame_compensator_top.sv
// Optical flow frame compensator, top level: controller and datapath.
// A byte item produces no result. An update without a latched frame goes straight
// to the result load; one with a frame passes through three product stages, a bias
// stage, a three-step reciprocal divide by 125, a saturation stage and the result load,
// which waits while a held result is stalled. One item is in work at a time. Reset is
// synchronous, active low, restores the coefficients and clears window and latch.
module optical_flow_frame_compensator_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration write port.
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    // Input channel.
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_action,
    input  logic [7:0]         i_rx_byte,
    input  logic signed [15:0] i_roll_rate,
    input  logic signed [15:0] i_pitch_rate,
    input  logic [15:0]        i_altitude_mm,
    // Output channel.
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_frame_found,
    output logic signed [15:0] o_x_motion_raw,
    output logic signed [15:0] o_y_motion_raw,
    output logic [7:0]         o_frame_quality,
    output logic signed [31:0] o_x_compensated,
    output logic signed [31:0] o_y_compensated
);

    // The controller sequences each update through the datapath. The input
    // transfer is only taken in the idle state, and the result register is
    // loaded only once the previous result has been transferred out, so a
    // waiting result blocks the input only once the following update is
    // ready to be loaded.
    offc_pkg::t_dp_cmd cmd;
    offc_pkg::t_dp_sts sts;

    offc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // The datapath holds the byte window, the frame latch, both compensation
    // lanes (x uses pitch rate, y uses roll rate) and the result register.
    offc_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_action          (i_action),
        .i_rx_byte         (i_rx_byte),
        .i_roll_rate       (i_roll_rate),
        .i_pitch_rate      (i_pitch_rate),
        .i_altitude_mm     (i_altitude_mm),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_frame_found     (o_frame_found),
        .o_x_motion_raw    (o_x_motion_raw),
        .o_y_motion_raw    (o_y_motion_raw),
        .o_frame_quality   (o_frame_quality),
        .o_x_compensated   (o_x_compensated),
        .o_y_compensated   (o_y_compensated)
    );

endmodule
